FILE: rtl/core/vtd_pkg.sv
// shared constants for the vertex tuple dedup core
`default_nettype none

package vtd_pkg;

  // payload field widths
  localparam int POS_W  = 20;
  localparam int ATTR_W = 21;
  localparam int NUM_W  = 12;

  // hash datapath
  localparam int          HASH_W    = 64;
  localparam int          BITCNT_W  = 6;
  localparam logic [63:0] HASH_SALT = 64'h9e37_79b9_7f4a_7c16;

  // default sizing
  localparam int TABLE_SLOTS_DEF = 4096;
  localparam int INDEX_BITS_DEF  = 20;

endpackage

`default_nettype wire

FILE: rtl/core/vtd_table.sv
// slot memory: one write port, one read port with registered read data
`default_nettype none

module vtd_table #(
  parameter int DEPTH  = vtd_pkg::TABLE_SLOTS_DEF,
  parameter int ADDR_W = $clog2(vtd_pkg::TABLE_SLOTS_DEF),
  parameter int DATA_W = 75
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/vtd_hash.sv
// key packing, three-round seed combine and reduction to a home slot
`default_nettype none

module vtd_hash #(
  parameter int TABLE_SLOTS = vtd_pkg::TABLE_SLOTS_DEF,
  parameter int INDEX_BITS  = vtd_pkg::INDEX_BITS_DEF,
  parameter int SLOT_W      = $clog2(vtd_pkg::TABLE_SLOTS_DEF),
  parameter int KEY_W       = 3 * vtd_pkg::INDEX_BITS_DEF + 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic        [vtd_pkg::POS_W-1:0]  position_key,
  input  wire logic signed [vtd_pkg::ATTR_W-1:0] normal_key,
  input  wire logic signed [vtd_pkg::ATTR_W-1:0] texture_key,
  output logic                                   done,
  output logic             [SLOT_W-1:0]          slot,
  output logic             [KEY_W-1:0]           key
);

  localparam int  HW         = vtd_pkg::HASH_W;
  localparam int  AW         = INDEX_BITS + 1;
  localparam bit  MOD_SERIAL = (TABLE_SLOTS & (TABLE_SLOTS - 1)) != 0;
  localparam logic [1:0] LAST_ROUND = 2'd2;

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MOD} hstate_t;

  hstate_t                              state_r;
  logic    [1:0]                        round_r;
  logic    [vtd_pkg::BITCNT_W-1:0]      bitcnt_r;
  logic    [HW-1:0]                     seed_r;
  logic    [SLOT_W-1:0]                 rem_r;
  logic    [SLOT_W-1:0]                 slot_r;
  logic                                 done_r;
  logic    [INDEX_BITS-1:0]             pos_r;
  logic    [AW-1:0]                     nrm_r;
  logic    [AW-1:0]                     tex_r;

  logic [HW-1:0]   pos_z, nrm_z, tex_z;
  logic [HW-1:0]   h_sel;
  logic [HW-1:0]   seed_mix;
  logic [SLOT_W:0] rem_sh;
  logic [SLOT_W-1:0] rem_nxt;

  // raw fields zero-extended, then cut to the key widths
  assign pos_z = {{(HW - vtd_pkg::POS_W){1'b0}}, position_key};
  assign nrm_z = {{(HW - vtd_pkg::ATTR_W){1'b0}}, normal_key};
  assign tex_z = {{(HW - vtd_pkg::ATTR_W){1'b0}}, texture_key};

  // identity hash of the key element for this round
  always_comb begin
    case (round_r)
      2'd0:    h_sel = HW'(pos_r);
      2'd1:    h_sel = HW'(signed'(nrm_r));
      default: h_sel = HW'(signed'(tex_r));
    endcase
  end

  // seed combine
  assign seed_mix = seed_r ^ (h_sel + vtd_pkg::HASH_SALT + (seed_r << 6) + (seed_r >> 2));

  // one remainder bit per cycle, msb first
  assign rem_sh  = {rem_r, seed_r[HW-1]};
  assign rem_nxt = (rem_sh >= (SLOT_W+1)'(TABLE_SLOTS))
                 ? SLOT_W'(rem_sh - (SLOT_W+1)'(TABLE_SLOTS))
                 : rem_sh[SLOT_W-1:0];

  // hash sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= H_IDLE;
      done_r   <= 1'b0;
      round_r  <= '0;
      bitcnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            pos_r   <= pos_z[INDEX_BITS-1:0];
            nrm_r   <= nrm_z[AW-1:0];
            tex_r   <= tex_z[AW-1:0];
            seed_r  <= '0;
            round_r <= '0;
            state_r <= H_MIX;
          end
        end
        H_MIX: begin
          seed_r  <= seed_mix;
          round_r <= round_r + 2'd1;
          if (round_r == LAST_ROUND) begin
            if (MOD_SERIAL) begin
              rem_r    <= '0;
              bitcnt_r <= '0;
              state_r  <= H_MOD;
            end else begin
              slot_r  <= seed_mix[SLOT_W-1:0];
              done_r  <= 1'b1;
              state_r <= H_IDLE;
            end
          end
        end
        H_MOD: begin
          seed_r   <= seed_r << 1;
          rem_r    <= rem_nxt;
          bitcnt_r <= bitcnt_r + 1'b1;
          if (bitcnt_r == vtd_pkg::BITCNT_W'(HW - 1)) begin
            slot_r  <= rem_nxt;
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;
  assign key  = {pos_r, nrm_r, tex_r};

endmodule

`default_nettype wire

FILE: rtl/core/vertex_tuple_dedup_core.sv
// vertex tuple dedup: hashed slot table with linear probing and dense numbering
//
//   channel  ports                                           direction
//   in       in_valid in_stall in_mode in_position_key
//            in_normal_key in_texture_key                    into the core
//   out      out_valid out_stall out_vertex_number
//            out_was_new out_overflow                        out of the core
//
// One item at a time. A lookup reads the probed slots one per cycle out of the slot
// memory, and when TABLE_SLOTS is not a power of two the home slot comes from a
// bit-serial remainder. A clear item sweeps the memory.
// After reset the same sweep runs with in_stall high.
// A result waits in the output register while the next item is taken in.
`default_nettype none

module vertex_tuple_dedup_core #(
  parameter int TABLE_SLOTS = vtd_pkg::TABLE_SLOTS_DEF,
  parameter int INDEX_BITS  = vtd_pkg::INDEX_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_mode,
  input  wire logic        [vtd_pkg::POS_W-1:0]  in_position_key,
  input  wire logic signed [vtd_pkg::ATTR_W-1:0] in_normal_key,
  input  wire logic signed [vtd_pkg::ATTR_W-1:0] in_texture_key,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [vtd_pkg::NUM_W-1:0]  out_vertex_number,
  output logic                                   out_was_new,
  output logic                                   out_overflow
);

  localparam int NUM_W  = vtd_pkg::NUM_W;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = 3 * INDEX_BITS + 2;
  localparam int ENT_W  = 1 + NUM_W + KEY_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_CHECK, S_DONE} state_t;

  state_t              state_r;
  logic [SLOT_W-1:0]   clr_cnt_r;
  logic                clr_res_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   probe_r;
  logic [NUM_W-1:0]    next_num_r;
  logic [NUM_W-1:0]    res_num_r;
  logic                res_new_r;
  logic                res_ovf_r;
  logic                out_valid_r;
  logic [NUM_W-1:0]    out_num_r;
  logic                out_new_r;
  logic                out_ovf_r;

  logic                hash_start;
  logic                hash_done;
  logic [SLOT_W-1:0]   hash_slot;
  logic [KEY_W-1:0]    hash_key;

  logic                tbl_we;
  logic [SLOT_W-1:0]   tbl_waddr;
  logic [ENT_W-1:0]    tbl_wdata;
  logic                tbl_re;
  logic [SLOT_W-1:0]   tbl_raddr;
  logic [ENT_W-1:0]    tbl_rdata;

  logic                ent_valid;
  logic [NUM_W-1:0]    ent_num;
  logic                key_match;
  logic [SLOT_W-1:0]   slot_inc;

  // input transfer only in idle
  assign in_stall   = (state_r != S_IDLE);
  assign hash_start = (state_r == S_IDLE) && in_valid && !in_mode;

  vtd_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .INDEX_BITS  (INDEX_BITS),
    .SLOT_W      (SLOT_W),
    .KEY_W       (KEY_W)
  ) u_hash (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (hash_start),
    .position_key (in_position_key),
    .normal_key   (in_normal_key),
    .texture_key  (in_texture_key),
    .done         (hash_done),
    .slot         (hash_slot),
    .key          (hash_key)
  );

  vtd_table #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // slot entry fields: valid, number, packed key
  assign ent_valid = tbl_rdata[ENT_W-1];
  assign ent_num   = tbl_rdata[NUM_W+KEY_W-1:KEY_W];
  assign key_match = (tbl_rdata[KEY_W-1:0] == hash_key);
  assign slot_inc  = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // memory access per state
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot_r;
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = slot_r;
    unique case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt_r;
      end
      S_HASH: begin
        tbl_re    = hash_done;
        tbl_raddr = hash_slot;
      end
      S_CHECK: begin
        if (!ent_valid) begin
          tbl_we    = 1'b1;
          tbl_wdata = {1'b1, next_num_r, hash_key};
        end else if (!key_match && probe_r != LAST_SLOT) begin
          tbl_re    = 1'b1;
          tbl_raddr = slot_inc;
        end
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      next_num_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= (clr_cnt_r == LAST_SLOT) ? '0 : clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_SLOT) begin
            next_num_r <= '0;
            if (clr_res_r) begin
              clr_res_r <= 1'b0;
              res_num_r <= '0;
              res_new_r <= 1'b0;
              res_ovf_r <= 1'b0;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_mode) begin
              clr_res_r <= 1'b1;
              state_r   <= S_CLEAR;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot_r  <= hash_slot;
            probe_r <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!ent_valid) begin
            res_num_r  <= next_num_r;
            res_new_r  <= 1'b1;
            res_ovf_r  <= 1'b0;
            next_num_r <= next_num_r + 1'b1;
            state_r    <= S_DONE;
          end else if (key_match) begin
            res_num_r <= ent_num;
            res_new_r <= 1'b0;
            res_ovf_r <= 1'b0;
            state_r   <= S_DONE;
          end else if (probe_r == LAST_SLOT) begin
            res_num_r <= '0;
            res_new_r <= 1'b0;
            res_ovf_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            slot_r  <= slot_inc;
            probe_r <= probe_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_num_r   <= res_num_r;
            out_new_r   <= res_new_r;
            out_ovf_r   <= res_ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_number = out_num_r;
  assign out_was_new       = out_new_r;
  assign out_overflow      = out_ovf_r;

  // a finished result never overwrites one still held by the consumer
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwritten while output stalled");

  // the hash unit only finishes while the sequencer waits for it
  a_hash_sync: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH))
    else $error("hash finished outside hash wait");

  // insert and overflow are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("was_new and overflow both set");

  // reset starts the clearing sweep at slot zero
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR && clr_cnt_r == '0))
    else $error("reset did not start clearing sweep");

endmodule

`default_nettype wire
